// File: hw/rtl/lsps_pkg.sv
`default_nettype none

package lsps_pkg;

  // Level table and machine size
  localparam int MAX_LEVELS = 64;
  localparam int MAX_NODES  = 64;

  localparam int LVL_W     = $clog2(MAX_LEVELS);
  localparam int LVL_CNT_W = LVL_W + 1;

  // Field widths
  localparam int NODE_W     = 7;
  localparam int OUT_NODE_W = 6;
  localparam int RUN_W      = 16;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_TOTAL = 1'b1;

  localparam logic              FIT_MODE_RST   = 1'b1;
  localparam logic [NODE_W-1:0] NODE_TOTAL_RST = NODE_W'(64);
  localparam logic [NODE_W-1:0] MAX_NODES_C    = NODE_W'(MAX_NODES);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PLACED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WIDE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // One classified item
  typedef struct packed {
    logic [NODE_W-1:0] need;
    logic [RUN_W-1:0]  run;
    logic              batch;
    logic              too_wide;
    logic              fit_mode;
    logic [NODE_W-1:0] width;
  } task_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [RUN_W-1:0]  b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W - RUN_W + 1){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lsps_front.sv
`default_nettype none

module lsps_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [lsps_pkg::NODE_W-1:0]    in_node_count,
  input  wire logic [lsps_pkg::RUN_W-1:0]     in_run_time,
  input  wire logic                           in_new_batch,
  input  wire logic                           cfg_we,
  input  wire logic [lsps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lsps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           q_full,
  output logic                                q_push,
  output lsps_pkg::task_t                     q_data
);

  logic                          fit_mode_r;
  logic [lsps_pkg::NODE_W-1:0]   node_total_r;
  logic [lsps_pkg::NODE_W-1:0]   width;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r   <= lsps_pkg::FIT_MODE_RST;
      node_total_r <= lsps_pkg::NODE_TOTAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsps_pkg::CFG_FIT_MODE:   fit_mode_r   <= cfg_wdata[0];
        lsps_pkg::CFG_NODE_TOTAL: node_total_r <= cfg_wdata[lsps_pkg::NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Machine width, clamped to the physical node count
  assign width = (node_total_r > lsps_pkg::MAX_NODES_C) ? lsps_pkg::MAX_NODES_C
                                                         : node_total_r;

  assign q_push = start && !q_full;

  always_comb begin
    q_data.need     = in_node_count;
    q_data.run      = in_run_time;
    q_data.batch    = in_new_batch;
    q_data.too_wide = in_node_count > width;
    q_data.fit_mode = fit_mode_r;
    q_data.width    = width;
  end

endmodule

`default_nettype wire

// File: hw/rtl/lsps_queue.sv
`default_nettype none

module lsps_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lsps_pkg::task_t  push_data,
  input  wire logic             pop,
  output lsps_pkg::task_t       pop_data,
  output logic                  full,
  output logic                  empty
);

  lsps_pkg::task_t                 slot_r [lsps_pkg::QUEUE_DEPTH];
  logic [lsps_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [lsps_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [lsps_pkg::QCNT_W-1:0]     count_r;
  logic                            do_pop;

  assign full     = count_r == lsps_pkg::QCNT_W'(lsps_pkg::QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// File: hw/rtl/lsps_back.sv
`default_nettype none

module lsps_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_empty,
  input  wire lsps_pkg::task_t                     q_data,
  output logic                                     q_pop,
  output logic                                     out_strobe,
  output logic [lsps_pkg::TIME_W-1:0]              out_start_time,
  output logic [lsps_pkg::TIME_W-1:0]              out_end_time,
  output logic [lsps_pkg::OUT_NODE_W-1:0]          out_first_node,
  output logic [lsps_pkg::OUT_NODE_W-1:0]          out_last_node,
  output logic [lsps_pkg::TIME_W-1:0]              out_makespan,
  output logic [lsps_pkg::STATUS_W-1:0]            out_status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_OPEN  = 3'd4;

  localparam logic [lsps_pkg::LVL_CNT_W-1:0] LVL_FULL =
    lsps_pkg::LVL_CNT_W'(lsps_pkg::MAX_LEVELS);

  // Level table
  logic [lsps_pkg::TIME_W-1:0] start_mem [lsps_pkg::MAX_LEVELS];
  logic [lsps_pkg::NODE_W-1:0] free_mem  [lsps_pkg::MAX_LEVELS];
  logic [lsps_pkg::TIME_W-1:0] rd_start_r;
  logic [lsps_pkg::NODE_W-1:0] rd_free_r;

  logic [2:0]                      state_r, state_nxt;
  lsps_pkg::task_t                 ent_r;
  logic [lsps_pkg::LVL_W-1:0]      idx_r, idx_nxt;
  logic [lsps_pkg::LVL_CNT_W-1:0]  used_r, used_nxt;
  logic [lsps_pkg::TIME_W-1:0]     height_r, height_nxt;

  logic                            mem_we;
  logic [lsps_pkg::LVL_W-1:0]      mem_wa;
  logic [lsps_pkg::TIME_W-1:0]     mem_wstart;
  logic [lsps_pkg::NODE_W-1:0]     mem_wfree;

  logic                            out_load;
  logic [lsps_pkg::TIME_W-1:0]     o_start, o_end, o_span;
  logic [lsps_pkg::NODE_W-1:0]     o_first, o_last;
  logic [lsps_pkg::STATUS_W-1:0]   o_status;

  logic [lsps_pkg::NODE_W-1:0]     free_clamp;
  logic [lsps_pkg::NODE_W-1:0]     first_fit;
  logic [lsps_pkg::LVL_CNT_W-1:0]  idx_inc;
  logic [lsps_pkg::TIME_W-1:0]     height_add;
  logic [lsps_pkg::TIME_W-1:0]     rd_end;

  logic                            out_strobe_r;
  logic [lsps_pkg::TIME_W-1:0]     out_start_r, out_end_r, out_span_r;
  logic [lsps_pkg::NODE_W-1:0]     out_first_r, out_last_r;
  logic [lsps_pkg::STATUS_W-1:0]   out_status_r;

  assign free_clamp = (rd_free_r > ent_r.width) ? ent_r.width : rd_free_r;
  assign first_fit  = ent_r.width - free_clamp;
  assign idx_inc    = {1'b0, idx_r} + 1'b1;
  assign height_add = lsps_pkg::sat_add(height_r, ent_r.run);
  assign rd_end     = lsps_pkg::sat_add(rd_start_r, ent_r.run);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    used_nxt   = used_r;
    height_nxt = height_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = idx_r;
    mem_wstart = rd_start_r;
    mem_wfree  = free_clamp - ent_r.need;
    out_load   = 1'b0;
    o_start    = '0;
    o_end      = '0;
    o_first    = '0;
    o_last     = '0;
    o_span     = height_r;
    o_status   = lsps_pkg::ST_PLACED;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = S_DISP;
          if (q_data.batch) begin
            used_nxt   = '0;
            height_nxt = '0;
          end
        end
      end

      S_DISP: begin
        if (ent_r.too_wide) begin
          out_load  = 1'b1;
          o_status  = lsps_pkg::ST_WIDE;
          state_nxt = S_IDLE;
        end else if (used_r == '0) begin
          state_nxt = S_OPEN;
        end else begin
          idx_nxt   = ent_r.fit_mode ? '0 : lsps_pkg::LVL_W'(used_r - 1'b1);
          state_nxt = S_READ;
        end
      end

      // memory read in flight
      S_READ: state_nxt = S_CHECK;

      S_CHECK: begin
        if (free_clamp >= ent_r.need) begin
          mem_we    = 1'b1;
          out_load  = 1'b1;
          o_start   = rd_start_r;
          o_end     = rd_end;
          o_first   = first_fit;
          o_last    = (ent_r.need == '0) ? first_fit : first_fit + ent_r.need - 1'b1;
          state_nxt = S_IDLE;
        end else if (!ent_r.fit_mode || idx_inc == used_r) begin
          state_nxt = S_OPEN;
        end else begin
          idx_nxt   = idx_inc[lsps_pkg::LVL_W-1:0];
          state_nxt = S_READ;
        end
      end

      S_OPEN: begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
        if (used_r == LVL_FULL) begin
          o_status = lsps_pkg::ST_FULL;
        end else begin
          mem_we     = 1'b1;
          mem_wa     = used_r[lsps_pkg::LVL_W-1:0];
          mem_wstart = height_r;
          mem_wfree  = ent_r.width - ent_r.need;
          used_nxt   = used_r + 1'b1;
          height_nxt = height_add;
          o_start    = height_r;
          o_end      = height_add;
          o_last     = (ent_r.need == '0) ? '0 : ent_r.need - 1'b1;
          o_span     = height_add;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      start_mem[mem_wa] <= mem_wstart;
      free_mem[mem_wa]  <= mem_wfree;
    end
    rd_start_r <= start_mem[idx_r];
    rd_free_r  <= free_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      height_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      height_r     <= height_nxt;
      out_strobe_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (q_pop) begin
      ent_r <= q_data;
    end
    if (out_load) begin
      out_start_r  <= o_start;
      out_end_r    <= o_end;
      out_first_r  <= o_first;
      out_last_r   <= o_last;
      out_span_r   <= o_span;
      out_status_r <= o_status;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_start_time = out_start_r;
  assign out_end_time   = out_end_r;
  assign out_first_node = out_first_r[lsps_pkg::OUT_NODE_W-1:0];
  assign out_last_node  = out_last_r[lsps_pkg::OUT_NODE_W-1:0];
  assign out_makespan   = out_span_r;
  assign out_status     = out_status_r;

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held two cycles");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= LVL_FULL)
    else $error("level count beyond table size");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r != lsps_pkg::ST_PLACED) |->
      (out_start_r == '0 && out_end_r == '0))
    else $error("rejected item carries nonzero times");

endmodule

`default_nettype wire

// File: hw/rtl/level_strip_packing_scheduler.sv
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+--------------------------------------------
// input     | start / busy         | in_node_count, in_run_time, in_new_batch
// result    | out_strobe (1 cycle) | out_start_time, out_end_time, out_first_node,
//           |                      | out_last_node, out_makespan, out_status
// config    | cfg_we               | cfg_index, cfg_wdata
//
// An item is taken when start is high and busy is low; busy is high only while
// the two-entry item queue is full. Each item gives one result, held for one cycle.
// Back end: a too-wide item is rejected in DISP; otherwise each level examined is
// a READ then a CHECK state (one level-table read), and OPEN adds a new level.
// One item is finished before the next is popped from the queue.
// Synchronous rst_n clears the queue, level count and makespan; config gets defaults.
// The result side cannot stall; results leave in arrival order.

module level_strip_packing_scheduler (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [lsps_pkg::NODE_W-1:0]       in_node_count,
  input  wire logic [lsps_pkg::RUN_W-1:0]        in_run_time,
  input  wire logic                              in_new_batch,
  input  wire logic                              cfg_we,
  input  wire logic [lsps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lsps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                                   out_strobe,
  output logic [lsps_pkg::TIME_W-1:0]            out_start_time,
  output logic [lsps_pkg::TIME_W-1:0]            out_end_time,
  output logic [lsps_pkg::OUT_NODE_W-1:0]        out_first_node,
  output logic [lsps_pkg::OUT_NODE_W-1:0]        out_last_node,
  output logic [lsps_pkg::TIME_W-1:0]            out_makespan,
  output logic [lsps_pkg::STATUS_W-1:0]          out_status
);

  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  lsps_pkg::task_t q_in;
  lsps_pkg::task_t q_out;

  assign busy = q_full;

  // Front: config registers, width clamp, too-wide check
  lsps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_node_count (in_node_count),
    .in_run_time   (in_run_time),
    .in_new_batch  (in_new_batch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  // Classified items wait here while the back end walks the level table
  lsps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: level table, fit search, level open, result register
  lsps_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .out_strobe     (out_strobe),
    .out_start_time (out_start_time),
    .out_end_time   (out_end_time),
    .out_first_node (out_first_node),
    .out_last_node  (out_last_node),
    .out_makespan   (out_makespan),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

// File: bench/level_strip_packing_scheduler_tb.sv
`default_nettype none

module level_strip_packing_scheduler_tb;

  // one placement as it leaves the block
  typedef struct packed {
    logic [lsps_pkg::TIME_W-1:0]     begin_at;
    logic [lsps_pkg::TIME_W-1:0]     finish_at;
    logic [lsps_pkg::OUT_NODE_W-1:0] first_node;
    logic [lsps_pkg::OUT_NODE_W-1:0] last_node;
    logic [lsps_pkg::TIME_W-1:0]     makespan;
    logic [lsps_pkg::STATUS_W-1:0]   status;
  } placement_t;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 500;

  // Shelf model: tracks open levels and the makespan, predicts each placement
  // and holds the placements still owed by the block, oldest first.
  class shelf_tracker;
    int unsigned                 shelf_start [lsps_pkg::MAX_LEVELS];
    int unsigned                 shelf_free  [lsps_pkg::MAX_LEVELS];
    int unsigned                 shelves_open;
    logic [lsps_pkg::TIME_W-1:0] height;
    bit                          first_fit;
    logic [lsps_pkg::NODE_W-1:0] node_total;
    placement_t                  owed[$];
    int unsigned                 errors;

    function new();
      shelves_open = 0;
      height       = '0;
      first_fit    = lsps_pkg::FIT_MODE_RST;
      node_total   = lsps_pkg::NODE_TOTAL_RST;
      errors       = 0;
    endfunction

    function logic [lsps_pkg::TIME_W-1:0] clip_add(logic [lsps_pkg::TIME_W-1:0] a,
                                                   logic [lsps_pkg::RUN_W-1:0] b);
      logic [lsps_pkg::TIME_W:0] s;
      s = {1'b0, a} + b;
      return s[lsps_pkg::TIME_W] ? {lsps_pkg::TIME_W{1'b1}} : s[lsps_pkg::TIME_W-1:0];
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // called for every accepted item
    function void place_task(logic [lsps_pkg::NODE_W-1:0] need,
                             logic [lsps_pkg::RUN_W-1:0] run, bit batch);
      int unsigned width, lvl, avail, first, last;
      bit          found;
      placement_t  p;
      width = (node_total > lsps_pkg::MAX_NODES) ? lsps_pkg::MAX_NODES : node_total;
      found = 0;
      lvl   = 0;
      p     = '0;
      if (batch) begin
        shelves_open = 0;
        height       = '0;
      end
      if (need > width) begin
        p.makespan = height;
        p.status   = lsps_pkg::ST_WIDE;
        owed.push_back(p);
        return;
      end
      if (first_fit) begin
        for (int i = 0; i < shelves_open; i++) begin
          avail = (shelf_free[i] > width) ? width : shelf_free[i];
          if (avail >= need) begin
            lvl   = i;
            found = 1;
            break;
          end
        end
      end else if (shelves_open > 0) begin
        avail = (shelf_free[shelves_open-1] > width) ? width : shelf_free[shelves_open-1];
        if (avail >= need) begin
          lvl   = shelves_open - 1;
          found = 1;
        end
      end
      if (!found) begin
        if (shelves_open >= lsps_pkg::MAX_LEVELS) begin
          p.makespan = height;
          p.status   = lsps_pkg::ST_FULL;
          owed.push_back(p);
          return;
        end
        lvl               = shelves_open;
        shelf_start[lvl]  = height;
        shelf_free[lvl]   = width;
        shelves_open++;
        height            = clip_add(height, run);
      end
      avail           = (shelf_free[lvl] > width) ? width : shelf_free[lvl];
      first           = width - avail;
      avail           = avail - need;
      shelf_free[lvl] = avail;
      last            = (need == 0) ? first : width - avail - 1;
      p.begin_at      = shelf_start[lvl];
      p.finish_at     = clip_add(shelf_start[lvl], run);
      p.first_node    = first[lsps_pkg::OUT_NODE_W-1:0];
      p.last_node     = last[lsps_pkg::OUT_NODE_W-1:0];
      p.makespan      = height;
      p.status        = lsps_pkg::ST_PLACED;
      owed.push_back(p);
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    function void cmp_field(string name, logic [lsps_pkg::TIME_W-1:0] exp,
                            logic [lsps_pkg::TIME_W-1:0] got);
      if (exp !== got)
        report($sformatf("%s mismatch: expected %0d, actual %0d", name, exp, got));
    endfunction

    function void check_placement(placement_t got);
      placement_t exp;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result: start %0d end %0d nodes %0d..%0d span %0d st %0d",
                         got.begin_at, got.finish_at, got.first_node, got.last_node,
                         got.makespan, got.status));
        return;
      end
      exp = owed.pop_front();
      cmp_field("begin_at",   exp.begin_at,   got.begin_at);
      cmp_field("finish_at",  exp.finish_at,  got.finish_at);
      cmp_field("first_node", exp.first_node, got.first_node);
      cmp_field("last_node",  exp.last_node,  got.last_node);
      cmp_field("makespan",   exp.makespan,   got.makespan);
      cmp_field("status",     exp.status,     got.status);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [lsps_pkg::NODE_W-1:0]     in_node_count = '0;
  logic [lsps_pkg::RUN_W-1:0]      in_run_time = '0;
  logic                            in_new_batch = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [lsps_pkg::CFG_IDX_W-1:0]  cfg_index = lsps_pkg::CFG_FIT_MODE;
  logic [lsps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            out_strobe;
  logic [lsps_pkg::TIME_W-1:0]     out_start_time;
  logic [lsps_pkg::TIME_W-1:0]     out_end_time;
  logic [lsps_pkg::OUT_NODE_W-1:0] out_first_node;
  logic [lsps_pkg::OUT_NODE_W-1:0] out_last_node;
  logic [lsps_pkg::TIME_W-1:0]     out_makespan;
  logic [lsps_pkg::STATUS_W-1:0]   out_status;

  shelf_tracker sb = new();
  bit           no_gaps = 0;     // burst stretches: start held high back to back
  int unsigned  items_sent = 0;
  int unsigned  quiet_cycles = 0;

  level_strip_packing_scheduler i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_node_count  (in_node_count),
    .in_run_time    (in_run_time),
    .in_new_batch   (in_new_batch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_strobe     (out_strobe),
    .out_start_time (out_start_time),
    .out_end_time   (out_end_time),
    .out_first_node (out_first_node),
    .out_last_node  (out_last_node),
    .out_makespan   (out_makespan),
    .out_status     (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor: results are checked before the item taken at the same edge is
  // noted, so a stray early result can't match a brand-new expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        sb.check_placement({out_start_time, out_end_time, out_first_node,
                            out_last_node, out_makespan, out_status});
      if (start && !busy)
        sb.place_task(in_node_count, in_run_time, in_new_batch);
      // watchdog: count edges where neither channel moves
      if (out_strobe || (start && !busy))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Drive one item; returns at the edge that accepted it, start left high
  // so a zero-gap follow-up keeps the line asserted.
  task automatic send_task(logic [lsps_pkg::NODE_W-1:0] need,
                           logic [lsps_pkg::RUN_W-1:0] run, bit batch);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_node_count <= need;
    in_run_time   <= run;
    in_new_batch  <= batch;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Drain: stop issuing, then wait for every owed placement.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Both registers are written on every reconfiguration, block idle first.
  task automatic reconfigure(bit mode, logic [lsps_pkg::NODE_W-1:0] total);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= lsps_pkg::CFG_FIT_MODE;
    cfg_wdata <= lsps_pkg::CFG_DATA_W'(mode);
    @(posedge clk);
    sb.first_fit = mode;
    cfg_index <= lsps_pkg::CFG_NODE_TOTAL;
    cfg_wdata <= total;
    @(posedge clk);
    sb.node_total = total;
    cfg_we <= 1'b0;
  endtask

  // One batch of tasks in decreasing run time, with a sprinkle of junk:
  // zero-width and over-wide tasks, unsorted run times, stray batch restarts.
  task automatic run_batch(int unsigned count, bit open_batch);
    int unsigned                 width;
    logic [lsps_pkg::RUN_W-1:0]  run;
    logic [lsps_pkg::NODE_W-1:0] need;
    bit                          batch;
    width = (sb.node_total > lsps_pkg::MAX_NODES) ? lsps_pkg::MAX_NODES : sb.node_total;
    if (width == 0) width = 1;
    run = ($urandom_range(0, 3) == 0) ? {lsps_pkg::RUN_W{1'b1}}
                                      : lsps_pkg::RUN_W'($urandom);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0:       need = '0;
        1:       need = lsps_pkg::NODE_W'($urandom_range(0, 127));
        default: need = lsps_pkg::NODE_W'($urandom_range(1, width));
      endcase
      if (k > 0) begin
        if ($urandom_range(0, 14) == 0)
          run = lsps_pkg::RUN_W'($urandom);
        else
          run = lsps_pkg::RUN_W'($urandom_range(0, run));
      end
      batch = (k == 0) ? open_batch : ($urandom_range(0, 29) == 0);
      send_task(need, run, batch);
    end
  endtask

  initial begin
    int unsigned                 phase;
    bit                          mode;
    logic [lsps_pkg::NODE_W-1:0] total;
    int unsigned                 n_batches, len;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset config, first-fit over 64 nodes
    send_task(7'd64, 16'hFFFF, 1'b1);  // full-width level
    send_task(7'd1,  16'd100,  1'b0);  // opens second level
    send_task(7'd0,  16'd5,    1'b0);  // zero width lands on a full level
    send_task(7'd65, 16'd7,    1'b0);  // one past the machine
    send_task(7'd127, 16'd0,   1'b0);  // widest code, too wide
    send_task(7'd63, 16'd50,   1'b0);  // fills rest of second level
    send_task(7'd0,  16'd3,    1'b1);  // zero width on empty table opens a level

    // next-fit over 10 nodes
    reconfigure(1'b0, 7'd10);
    send_task(7'd6,  16'd900, 1'b1);
    send_task(7'd5,  16'd800, 1'b0);   // doesn't fit newest -> new level
    send_task(7'd4,  16'd700, 1'b0);   // fits newest
    send_task(7'd6,  16'd600, 1'b0);   // fits no open level -> new level
    send_task(7'd10, 16'd500, 1'b0);
    send_task(7'd11, 16'd400, 1'b0);   // too wide

    // zero machine width: only zero-width tasks fit
    reconfigure(1'b1, 7'd0);
    send_task(7'd0, 16'd9, 1'b1);
    send_task(7'd1, 16'd8, 1'b0);

    // node_total above the clamp
    reconfigure(1'b1, 7'd127);
    send_task(7'd64, 16'd20, 1'b1);
    send_task(7'd65, 16'd19, 1'b0);

    // width shrinks mid-batch: old free counts get clamped
    reconfigure(1'b1, 7'd64);
    send_task(7'd10, 16'd40, 1'b1);
    reconfigure(1'b1, 7'd8);
    send_task(7'd3, 16'd30, 1'b0);
    send_task(7'd8, 16'd20, 1'b0);

    // --- random phases: extremes first, then random settings
    phase = 0;
    while (items_sent < RANDOM_ITEMS + 20) begin
      case (phase)
        0:       begin mode = 1'b0; total = 7'd1;   end
        1:       begin mode = 1'b1; total = 7'd1;   end
        2:       begin mode = 1'b0; total = 7'd64;  end
        3:       begin mode = 1'b1; total = 7'd64;  end
        4:       begin mode = 1'b1; total = 7'd127; end
        5:       begin mode = 1'b0; total = 7'd0;   end
        default: begin
          mode  = $urandom_range(0, 1);
          total = ($urandom_range(0, 3) == 0) ? lsps_pkg::NODE_W'($urandom_range(0, 127))
                                              : lsps_pkg::NODE_W'($urandom_range(1, 64));
        end
      endcase
      reconfigure(mode, total);
      no_gaps   = ($urandom_range(0, 3) == 0);
      n_batches = $urandom_range(1, 3);
      for (int b = 0; b < n_batches; b++) begin
        // narrow machines get long batches now and then to run the table out
        if (phase < 2 || (total <= 2 && $urandom_range(0, 1) == 0))
          len = $urandom_range(66, 75);
        else
          len = $urandom_range(1, 24);
        // occasionally keep the old levels across a width change
        run_batch(len, !(b == 0 && phase > 5 && $urandom_range(0, 4) == 0));
      end
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
